[src/opdt_pkg.sv]
// Shared types, constants and helpers of the obstacle dedup table.
package opdt_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUB_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUB_PHASE    = 2'd2;

    localparam logic [31:0] MATCH_TOL_RESET  = 32'd6554;   // 0.1 in Q16.16
    localparam logic [7:0]  PUB_PERIOD_RESET = 8'd10;
    localparam logic [7:0]  PUB_PHASE_RESET  = 8'd1;

    // Command passed from the front to the back through the queue.
    typedef struct packed {
        logic        entry_valid;
        logic [31:0] obstacle_x;
        logic [31:0] obstacle_y;
        logic [7:0]  obstacle_color;
        logic [31:0] obstacle_radius;
        logic        msg_start;
        logic        publish_now;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DONE
    } t_back_state;

    // |d| < tol for a 33-bit signed difference d.
    function automatic logic within_tol(input logic [32:0] d, input logic [31:0] tol);
        logic [33:0] s;
        s = {d[32], d} + {2'b00, tol};
        if (d[32]) begin
            within_tol = !s[33] && (s != 34'd0);
        end else begin
            within_tol = d[31:0] < tol;
        end
    endfunction

endpackage

[src/opdt_front.sv]
// Front end: accepts beats, tracks message boundaries and the publish counter.
module opdt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [103:0]    i_s_tdata,   // obstacle_x, obstacle_y, obstacle_color, obstacle_radius
    input  logic            i_s_tuser,   // entry_valid
    input  logic            i_s_tlast,
    input  logic [7:0]      i_period,
    input  logic [7:0]      i_phase,
    input  logic            i_q_full,
    output logic            o_q_push,
    output opdt_pkg::t_cmd  o_q_cmd
);
    import opdt_pkg::*;

    logic       r_at_start;
    logic [7:0] r_msg_cnt;
    logic [7:0] n_msg_cnt;
    logic [8:0] cnt_inc;

    assign o_s_tready = !i_q_full;
    assign o_q_push   = i_s_tvalid && !i_q_full;

    assign cnt_inc = {1'b0, r_msg_cnt} + 9'd1;

    always_comb begin
        // wrap when the advanced counter reaches the period
        if (cnt_inc >= {1'b0, i_period}) begin
            n_msg_cnt = 8'd0;
        end else begin
            n_msg_cnt = cnt_inc[7:0];
        end
    end

    always_comb begin
        o_q_cmd.entry_valid     = i_s_tuser;
        o_q_cmd.obstacle_x      = i_s_tdata[31:0];
        o_q_cmd.obstacle_y      = i_s_tdata[63:32];
        o_q_cmd.obstacle_color  = i_s_tdata[71:64];
        o_q_cmd.obstacle_radius = i_s_tdata[103:72];
        o_q_cmd.msg_start       = r_at_start;
        o_q_cmd.publish_now     = i_s_tlast && (r_msg_cnt == i_phase);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_msg_cnt  <= 8'd0;
        end else if (o_q_push) begin
            r_at_start <= i_s_tlast;
            if (i_s_tlast) begin
                r_msg_cnt <= n_msg_cnt;
            end
        end
    end

endmodule

[src/opdt_fifo.sv]
// Two-entry command queue between front and back.
module opdt_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  opdt_pkg::t_cmd  i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output opdt_pkg::t_cmd  o_data
);
    import opdt_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[src/opdt_back.sv]
// Back end: scans the stored table for a near entry, appends, and registers the result.
module opdt_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  opdt_pkg::t_cmd  i_q_cmd,
    output logic            o_q_pop,
    input  logic [31:0]     i_tolerance,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [15:0]     o_m_tdata,   // entry_count
    output logic [3:0]      o_m_tuser    // was_added, was_duplicate, table_full, publish_now
);
    import opdt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [31:0] mem_x      [TABLE_DEPTH];
    logic [31:0] mem_y      [TABLE_DEPTH];
    logic [7:0]  mem_color  [TABLE_DEPTH];
    logic [31:0] mem_radius [TABLE_DEPTH];

    t_back_state r_state;
    t_back_state n_state;
    t_cmd        r_cmd;
    logic        r_bulk;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_issue;
    logic        r_p1;
    logic        r_p2;
    logic        r_dup;
    logic [31:0] r_rd_x;
    logic [31:0] r_rd_y;
    logic [32:0] r_dx;
    logic [32:0] r_dy;
    logic        r_out_valid;
    logic [3:0]  r_out_user;
    logic [8:0]  r_out_count;

    logic          rd_en;
    logic          hit;
    logic          tab_full;
    logic          out_free;
    logic          bulk_now;
    logic          do_add;
    logic [CW-1:0] count_after;
    logic [CW+8:0] count_wide;

    assign rd_en    = (r_state == B_SCAN) && (r_issue < r_count);
    assign hit      = r_p2 && within_tol(r_dx, i_tolerance) && within_tol(r_dy, i_tolerance);
    assign tab_full = (r_count == CW'(TABLE_DEPTH));
    assign out_free = !r_out_valid || i_m_tready;
    assign bulk_now = i_q_cmd.msg_start ? (r_count == '0) : r_bulk;
    assign do_add   = r_cmd.entry_valid && !r_dup && !tab_full;
    assign count_after = do_add ? (r_count + CW'(1)) : r_count;
    assign count_wide  = (CW + 9)'(count_after);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_user;
    assign o_m_tdata  = {7'd0, r_out_count};

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    // scan only outside bulk fill and when something is stored
                    if (i_q_cmd.entry_valid && !bulk_now && (r_count != '0)) begin
                        n_state = B_SCAN;
                    end else begin
                        n_state = B_DONE;
                    end
                end
            end
            B_SCAN: begin
                if (hit || ((r_issue == r_count) && !r_p1)) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_bulk      <= 1'b0;
            r_count     <= '0;
            r_issue     <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_dup       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == B_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_bulk  <= bulk_now;
                        r_issue <= '0;
                        r_p1    <= 1'b0;
                        r_p2    <= 1'b0;
                        r_dup   <= 1'b0;
                    end
                end
                B_SCAN: begin
                    if (rd_en) begin
                        r_issue <= r_issue + CW'(1);
                    end
                    r_p1 <= rd_en;
                    r_p2 <= r_p1;
                    if (hit) begin
                        r_dup <= 1'b1;
                    end
                end
                B_DONE: begin
                    if (out_free) begin
                        r_count <= count_after;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // scan datapath: read, subtract, then compare
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (rd_en) begin
            r_rd_x <= mem_x[r_issue[AW-1:0]];
            r_rd_y <= mem_y[r_issue[AW-1:0]];
        end
        r_dx <= {r_cmd.obstacle_x[31], r_cmd.obstacle_x} - {r_rd_x[31], r_rd_x};
        r_dy <= {r_cmd.obstacle_y[31], r_cmd.obstacle_y} - {r_rd_y[31], r_rd_y};
        if ((r_state == B_DONE) && out_free) begin
            r_out_user  <= {r_cmd.publish_now,
                            r_cmd.entry_valid && !r_dup && tab_full,
                            r_dup,
                            do_add};
            r_out_count <= count_wide[8:0];
        end
    end

    // append the new obstacle
    always_ff @(posedge i_clk) begin
        if ((r_state == B_DONE) && out_free && do_add) begin
            mem_x[r_count[AW-1:0]]      <= r_cmd.obstacle_x;
            mem_y[r_count[AW-1:0]]      <= r_cmd.obstacle_y;
            mem_color[r_count[AW-1:0]]  <= r_cmd.obstacle_color;
            mem_radius[r_count[AW-1:0]] <= r_cmd.obstacle_radius;
        end
    end

endmodule

[src/obstacle_proximity_dedup_table_core.sv]
// Top level of the obstacle proximity dedup table: config registers, front, queue, back.
// Each input beat carries one detected obstacle of a radar message; each yields one
// result beat telling whether the obstacle was appended, matched a stored entry within
// match_tolerance in both x and y, or was dropped on a full table, plus the publish
// strobe, set on the last beat of a message whose count equals the phase, and the entry
// count after the beat. For an item that needs a duplicate check, the back end reads one
// entry per cycle from the coordinate memory through a three-stage read/subtract/compare
// pipeline and stops at the first match; empty items, bulk-fill items and items on an
// empty table skip the scan. A two-entry queue lets the front keep accepting beats while
// the back is scanning. The user must write configuration only while the block is idle;
// the block itself does not enforce it.
module obstacle_proximity_dedup_table_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [103:0]                    i_s_tdata,  // obstacle_x, obstacle_y, obstacle_color, obstacle_radius
    input  logic                            i_s_tuser,  // entry_valid
    input  logic                            i_s_tlast,  // message_last
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [15:0]                     o_m_tdata,  // entry_count
    output logic [3:0]                      o_m_tuser,  // was_added, was_duplicate, table_full, publish_now
    input  logic                            i_cfg_we,
    input  logic [opdt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]                     i_cfg_data
);
    import opdt_pkg::*;

    logic [31:0] r_tolerance;
    logic [7:0]  r_period;
    logic [7:0]  r_phase;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd q_in;
    t_cmd q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= MATCH_TOL_RESET;
            r_period    <= PUB_PERIOD_RESET;
            r_phase     <= PUB_PHASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MATCH_TOL:  r_tolerance <= i_cfg_data;
                REG_PUB_PERIOD: r_period    <= i_cfg_data[7:0];
                REG_PUB_PHASE:  r_phase     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    opdt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_period   (r_period),
        .i_phase    (r_phase),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in)
    );

    opdt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    opdt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out),
        .o_q_pop     (q_pop),
        .i_tolerance (r_tolerance),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

`ifndef NO_ASSERTIONS
    // an obstacle has exactly one fate at most
    a_one_fate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $onehot0(o_m_tuser[2:0]))
        else $error("more than one of added/duplicate/full set");

    // queue drains on reset, so the input side is open right after it
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready after reset");

    // no result beat right after reset, before any command can have entered the queue
    a_no_early_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat right after reset");
`endif

endmodule
